### src/tomap_pkg.sv
// Package: shared constants and types for the third-order transport map.
package tomap_pkg;

  localparam int NCOORD      = 6;
  localparam int STORE_DEPTH = 504;
  localparam int ADDR_W      = 9;
  localparam int WORD_W      = 32;
  localparam int R_BASE      = 6;
  localparam int T_BASE      = 42;
  localparam int Q_BASE      = 168;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TRACK = 1'b1;

  // Request from the sequencer to the shared multiply unit
  typedef struct packed {
    logic               start;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
  } mul_req_t;

  // Result of the shared multiply unit
  typedef struct packed {
    logic               done;
    logic signed [63:0] prod;
  } mul_rsp_t;

endpackage

### src/tomap_mul.sv
// Module: shared signed 32x32 multiplier with registered operands and a registered product.
module tomap_mul
  import tomap_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic signed [31:0] a_r, b_r;
  logic               v1_r;
  logic signed [63:0] p_r;
  logic               v2_r;

  // Register operands, then the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req.start;
      v2_r <= v1_r;
    end
    a_r <= req.op_a;
    b_r <= req.op_b;
    p_r <= a_r * b_r;
  end

  assign rsp.done = v2_r;
  assign rsp.prod = p_r;

endmodule

### src/third_order_transport_map_top.sv
// Module: top level of the third-order transport map with sequencer and store.
//
//  channel | direction | contents
//  in_*    | slave     | tuser: command; tdata: coef_index, coef_value, coord_x..coord_dp,
//          |           | particle_id; tlast: batch_last
//  out_*   | master    | tdata: out_x..out_dp, out_id; tuser: overflow; tlast: out_last
//  cfg_*   | slave     | cfg_data: map_order
//
// A load beat is written to the store as it is taken, and the next beat may follow at once.
// A track beat runs every product, each R, T and Q term and each monomial, through one
// shared multiplier, one product at a time, and no beat is accepted until it is done.
// Reset clears the store by a sweep over all 504 words, with no beat accepted meanwhile.
// A finished result moves to the output register; the next beat is taken while it waits,
// and the sequencer holds only when a second result is ready before the first has gone.
module third_order_transport_map_top
  import tomap_pkg::*;
#(
  parameter int FRAC_BITS = 16
)(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata from bit 0: coef_index[8:0], coef_value[40:9], coord_x[72:41],
  // coord_xp[104:73], coord_y[136:105], coord_yp[168:137], coord_s[200:169],
  // coord_dp[232:201], particle_id[264:233], zero fill[271:265]
  input  logic [271:0] in_tdata,
  // tuser: command[0]
  input  logic         in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata from bit 0: out_x[31:0], out_xp[63:32], out_y[95:64], out_yp[127:96],
  // out_s[159:128], out_dp[191:160], out_id[223:192]
  output logic [223:0] out_tdata,
  // tuser: overflow[0]
  output logic         out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_CREAD, S_TERM, S_TWAIT, S_M2, S_M2WAIT,
    S_M3, S_M3WAIT, S_NEXT, S_OUTI, S_DONE
  } state_t;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  state_t state_r;
  logic [1:0] order_r;
  logic [ADDR_W-1:0] clr_r;
  logic signed [31:0] mem [STORE_DEPTH];
  logic signed [31:0] rd_r;
  logic [ADDR_W-1:0] ra;
  logic signed [31:0] x_r [NCOORD];
  logic [31:0] id_r;
  logic last_r;
  logic [2:0] i_r, j_r, k_r, l_r;
  logic [1:0] ph_r; // 0 C, 1 R, 2 T, 3 Q
  logic [ADDR_W-1:0] addr_r;
  logic signed [63:0] sum_r;
  logic signed [31:0] m2_r, m3_r;
  logic signed [31:0] res_r [NCOORD];
  logic ovf_r;
  logic ov_r;
  logic signed [31:0] out_res_r [NCOORD];
  logic [31:0] out_id_r;
  logic out_last_r;
  logic out_ovf_r;
  mul_req_t req;
  mul_rsp_t rsp;

  tomap_mul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > MAX32) return 32'sh7fffffff;
    if (v < MIN32) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [1:0] ord;
  assign ord = (order_r == 2'd0) ? 2'd1 : order_r;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = ov_r;

  always_comb begin
    out_tdata = '0;
    for (int n = 0; n < NCOORD; n++) out_tdata[32*n +: 32] = out_res_r[n];
    out_tdata[223:192] = out_id_r;
  end
  assign out_tuser = out_ovf_r;
  assign out_tlast = out_last_r;

  // Read address of the store for the coming coefficient
  assign ra = addr_r;

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) mem[clr_r] <= '0;
    else if (in_tvalid && in_tready && in_tuser == CMD_LOAD
             && in_tdata[8:0] < ADDR_W'(STORE_DEPTH))
      mem[in_tdata[8:0]] <= in_tdata[40:9];
    rd_r <= mem[ra];
  end

  // Operand selection for the multiplier
  always_comb begin
    req.start = 1'b0;
    req.op_a = rd_r;
    req.op_b = x_r[j_r];
    case (state_r)
      S_TERM: begin
        req.start = (ph_r != 2'd0);
        req.op_a = rd_r;
        case (ph_r)
          2'd1: req.op_b = x_r[j_r];
          2'd2: req.op_b = m2_r;
          2'd3: req.op_b = m3_r;
          default: req.op_b = '0;
        endcase
      end
      S_M2: begin
        req.start = 1'b1;
        req.op_a = x_r[j_r];
        req.op_b = x_r[k_r];
      end
      S_M3: begin
        req.start = 1'b1;
        req.op_a = m2_r;
        req.op_b = x_r[l_r];
      end
      default: ;
    endcase
  end

  logic signed [63:0] sh;
  assign sh = rsp.prod >>> FRAC_BITS;

  // Tetrahedral offset j(j+1)(j+2)/6 of the cubic block
  function automatic int tet(input logic [2:0] j);
    case (j)
      3'd0: return 0;
      3'd1: return 1;
      3'd2: return 4;
      3'd3: return 10;
      3'd4: return 20;
      default: return 35;
    endcase
  endfunction

  // Address of T[i][j][k] and Q[i][j][k][l]
  function automatic logic [ADDR_W-1:0] t_addr(input logic [2:0] i, j, k);
    return ADDR_W'(T_BASE + 21 * int'(i) + (int'(j) * (int'(j) + 1)) / 2 + int'(k));
  endfunction
  function automatic logic [ADDR_W-1:0] q_addr(input logic [2:0] i, j, k, l);
    return ADDR_W'(Q_BASE + 56 * int'(i) + tet(j)
                   + (int'(k) * (int'(k) + 1)) / 2 + int'(l));
  endfunction

  // Sequencer: walk C, R, then at order 2 and up for each (j,k) T and at order 3 the Q terms below it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      order_r <= 2'd1;
      ov_r <= 1'b0;
    end else begin
      if (cfg_valid) order_r <= cfg_data;
      // fill the output register from the sequencer, empty it on a taken beat
      if (state_r == S_DONE && (!ov_r || out_tready)) ov_r <= 1'b1;
      else if (ov_r && out_tready) ov_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == ADDR_W'(STORE_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid && in_tready && in_tuser == CMD_TRACK) begin
            for (int n = 0; n < NCOORD; n++) x_r[n] <= in_tdata[41 + 32*n +: 32];
            id_r <= in_tdata[264:233];
            last_r <= in_tlast;
            ovf_r <= 1'b0;
            i_r <= '0;
            state_r <= S_START;
          end
        end
        S_START: begin
          // begin output i: fetch C[i]
          addr_r <= ADDR_W'(i_r);
          ph_r <= 2'd0;
          j_r <= '0; k_r <= '0; l_r <= '0;
          state_r <= S_CREAD;
        end
        S_CREAD: state_r <= S_TERM; // read latency
        S_TERM: begin
          if (ph_r == 2'd0) begin
            sum_r <= 64'(rd_r);
            ph_r <= 2'd1;
            addr_r <= ADDR_W'(R_BASE + 6 * int'(i_r));
            state_r <= S_CREAD;
          end else state_r <= S_TWAIT;
        end
        S_TWAIT: begin
          if (rsp.done) begin
            sum_r <= sum_r + sh;
            state_r <= S_NEXT;
          end
        end
        S_M2: state_r <= S_M2WAIT;
        S_M2WAIT: begin
          if (rsp.done) begin
            m2_r <= sat(sh);
            ph_r <= 2'd2;
            addr_r <= t_addr(i_r, j_r, k_r);
            state_r <= S_CREAD;
          end
        end
        S_M3: state_r <= S_M3WAIT;
        S_M3WAIT: begin
          if (rsp.done) begin
            m3_r <= sat(sh);
            ph_r <= 2'd3;
            addr_r <= q_addr(i_r, j_r, k_r, l_r);
            state_r <= S_CREAD;
          end
        end
        S_NEXT: begin
          case (ph_r)
            2'd1: begin
              if (j_r != 3'd5) begin
                j_r <= j_r + 1'b1;
                addr_r <= addr_r + 1'b1;
                state_r <= S_CREAD;
              end else if (ord >= 2'd2) begin
                j_r <= '0; k_r <= '0;
                state_r <= S_M2;
              end else state_r <= S_OUTI;
            end
            2'd2: begin
              if (ord == 2'd3) begin
                l_r <= '0;
                state_r <= S_M3;
              end else state_r <= S_OUTI; // advance (j,k) below
            end
            2'd3: begin
              if (l_r != k_r) begin
                l_r <= l_r + 1'b1;
                state_r <= S_M3;
              end else state_r <= S_OUTI;
            end
            default: state_r <= S_OUTI;
          endcase
          // step the (j,k) pair once its T and Q terms are done
          if ((ph_r == 2'd2 && ord != 2'd3) || (ph_r == 2'd3 && l_r == k_r)) begin
            if (k_r != j_r) begin
              k_r <= k_r + 1'b1;
              state_r <= S_M2;
            end else if (j_r != 3'd5) begin
              j_r <= j_r + 1'b1;
              k_r <= '0;
              state_r <= S_M2;
            end else state_r <= S_OUTI;
          end
        end
        S_OUTI: begin
          res_r[i_r] <= sat(sum_r);
          if (sum_r > MAX32 || sum_r < MIN32) ovf_r <= 1'b1;
          if (i_r == 3'd5) state_r <= S_DONE;
          else begin
            i_r <= i_r + 1'b1;
            state_r <= S_START;
          end
        end
        S_DONE: begin
          // hold until the output register is free, then hand the result over
          if (!ov_r || out_tready) begin
            for (int n = 0; n < NCOORD; n++) out_res_r[n] <= res_r[n];
            out_id_r <= id_r;
            out_last_r <= last_r;
            out_ovf_r <= ovf_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/third_order_transport_map_top_tb.sv
// Testbench for the third-order transport map: directed table, then random loads and tracks.
`timescale 1ns / 100ps

module third_order_transport_map_top_tb
  import tomap_pkg::*;
;

  localparam int FRAC = 16;
  localparam longint CYCLE_LIMIT = 64'd10_000_000;

  typedef struct {
    logic               cmd;
    logic [8:0]         addr;
    logic signed [31:0] value;
    logic signed [31:0] coord [NCOORD];
    logic [31:0]        pid;
    logic               last;
  } beat_t;

  typedef struct {
    logic signed [31:0] coord [NCOORD];
    logic [31:0]        pid;
    logic               last;
    logic               ovf;
  } track_res_t;

  // Directed table row: optional typed-in expectation
  typedef struct {
    beat_t      b;
    bit         fixed;
    track_res_t res;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [271:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [223:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_data = '0;

  logic signed [31:0] coef_mirror [STORE_DEPTH];
  logic [1:0]         order_mirror;
  track_res_t         pending_tracks [$];
  int                 mismatches = 0;
  longint             cycles = 0;
  bit                 hold_long = 1'b0;

  third_order_transport_map_top i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("third_order_transport_map_top_tb NOT OK");
      $finish;
    end
  end

  function automatic logic signed [63:0] asr(logic signed [63:0] v);
    return v >>> FRAC;
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v, ref bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Map one particle through the mirrored coefficients
  function automatic track_res_t map_particle(beat_t b);
    track_res_t r;
    logic signed [63:0] x [NCOORD];
    logic signed [63:0] sum, m2, m3;
    bit ovf, junk;
    int ord, tix, qix;
    ovf = 1'b0;
    ord = (order_mirror == 2'd0) ? 1 : order_mirror;
    for (int j = 0; j < NCOORD; j++) x[j] = b.coord[j];
    for (int i = 0; i < NCOORD; i++) begin
      sum = coef_mirror[i];
      for (int j = 0; j < NCOORD; j++)
        sum += asr(64'(coef_mirror[R_BASE + 6*i + j]) * x[j]);
      if (ord >= 2) begin
        for (int j = 0; j < NCOORD; j++) begin
          for (int k = 0; k <= j; k++) begin
            junk = 1'b0;
            m2 = clamp32(asr(x[j] * x[k]), junk);
            tix = T_BASE + 21*i + j*(j+1)/2 + k;
            sum += asr(64'(coef_mirror[tix]) * m2);
            if (ord >= 3) begin
              for (int l = 0; l <= k; l++) begin
                m3 = clamp32(asr(m2 * x[l]), junk);
                qix = Q_BASE + 56*i + j*(j+1)*(j+2)/6 + k*(k+1)/2 + l;
                sum += asr(64'(coef_mirror[qix]) * m3);
              end
            end
          end
        end
      end
      r.coord[i] = 32'(clamp32(sum, ovf));
    end
    r.pid = b.pid;
    r.last = b.last;
    r.ovf = ovf;
    return r;
  endfunction

  // Apply an accepted load to the mirror, or queue the result of an accepted track
  task automatic absorb(beat_t b, bit fixed, track_res_t res);
    if (b.cmd == CMD_LOAD) begin
      if (b.addr < STORE_DEPTH) coef_mirror[b.addr] = b.value;
    end else begin
      pending_tracks.push_back(fixed ? res : map_particle(b));
    end
  endtask

  function automatic logic [271:0] pack_beat(beat_t b);
    logic [271:0] d;
    d = '0;
    d[8:0] = b.addr;
    d[40:9] = b.value;
    for (int j = 0; j < NCOORD; j++) d[41 + 32*j +: 32] = b.coord[j];
    d[264:233] = b.pid;
    return d;
  endfunction

  // Offer one beat and wait until it is taken; gaps between bursts come from idle_in
  task automatic send(beat_t b, bit fixed = 1'b0, track_res_t res = '{default: '0});
    in_tvalid <= 1'b1;
    in_tdata <= pack_beat(b);
    in_tuser <= b.cmd;
    in_tlast <= b.last;
    do @(posedge clk); while (!in_tready);
    absorb(b, fixed, res);
  endtask

  task automatic idle_in(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_and_config(logic [1:0] ord);
    in_tvalid <= 1'b0;
    while (pending_tracks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= ord;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    order_mirror = ord;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(131072)) - 32'd65536);
      3: return $signed($urandom()) >>> $urandom_range(20, 8);
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic beat_t rand_track();
    beat_t b;
    b.cmd = CMD_TRACK;
    b.addr = 9'($urandom());
    b.value = $signed($urandom());
    for (int j = 0; j < NCOORD; j++) b.coord[j] = rand_word();
    b.pid = $urandom();
    b.last = 1'($urandom());
    return b;
  endfunction

  function automatic beat_t rand_load();
    beat_t b;
    b = rand_track();
    b.cmd = CMD_LOAD;
    b.addr = ($urandom_range(15) == 0) ? 9'($urandom_range(511, 504))
                                       : 9'($urandom_range(STORE_DEPTH - 1));
    b.value = rand_word();
    return b;
  endfunction

  // Receiver: random stall pattern, plus one long hold-off
  initial begin
    int stretch;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (6000) @(posedge clk);
        hold_long = 1'b0;
      end
      stretch = $urandom_range(3);
      case (stretch)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(3) != 0);
        default: out_tready <= 1'b0;
      endcase
      repeat ($urandom_range(30)) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    track_res_t want;
    bit bad;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tracks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        want = pending_tracks.pop_front();
        bad = 1'b0;
        for (int j = 0; j < NCOORD; j++)
          if (out_tdata[32*j +: 32] !== want.coord[j]) bad = 1'b1;
        if (out_tdata[223:192] !== want.pid || out_tuser !== want.ovf ||
            out_tlast !== want.last) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: coords %h id %h ovf %b last %b, got %h ovf %b last %b",
                     {want.coord[5], want.coord[4], want.coord[3], want.coord[2],
                      want.coord[1], want.coord[0]}, want.pid, want.ovf, want.last,
                     out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  // Stimulus
  initial begin
    row_t        rows [$];
    row_t        r;
    beat_t       b;
    track_res_t  e;
    logic [1:0]  orders [5] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd3};
    int          burst;

    foreach (coef_mirror[n]) coef_mirror[n] = '0;
    order_mirror = 2'd1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Cleared store after reset: zero coordinates, id and marker pass through
    b = rand_track();
    b.pid = 32'hFFFF_FFFF;
    b.last = 1'b1;
    e.coord = '{default: '0};
    e.pid = 32'hFFFF_FFFF;
    e.last = 1'b1;
    e.ovf = 1'b0;
    rows.push_back('{b, 1'b1, e});
    // Constant terms at the extremes, loads beyond the store ignored
    for (int i = 0; i < NCOORD; i++) begin
      b = rand_load();
      b.addr = 9'(i);
      b.value = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      rows.push_back('{b, 1'b0, e});
    end
    b = rand_load();
    b.addr = 9'd511;
    b.value = 32'sh1234_5678;
    rows.push_back('{b, 1'b0, e});
    b = rand_load();
    b.addr = 9'd504;
    rows.push_back('{b, 1'b0, e});
    b = rand_track();
    b.pid = 32'h0;
    b.last = 1'b0;
    for (int i = 0; i < NCOORD; i++) e.coord[i] = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    e.pid = 32'h0;
    e.last = 1'b0;
    rows.push_back('{b, 1'b1, e});
    // Random linear terms, a quadratic and a cubic diagonal term, then extreme coordinates
    foreach (orders[n]) begin
      b = rand_load();
      b.addr = 9'(R_BASE + $urandom_range(35));
      b.value = 32'sh0001_0000;
      rows.push_back('{b, 1'b0, e});
    end
    b = rand_load(); b.addr = 9'(T_BASE + 20); b.value = 32'sh7FFF_FFFF;
    rows.push_back('{b, 1'b0, e});
    b = rand_load(); b.addr = 9'(STORE_DEPTH - 1); b.value = 32'sh8000_0000;
    rows.push_back('{b, 1'b0, e});
    for (int n = 0; n < 4; n++) begin
      b = rand_track();
      for (int j = 0; j < NCOORD; j++)
        b.coord[j] = (n[0] ^ j[0]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      rows.push_back('{b, 1'b0, e});
    end

    // Walk the table under the first three orders, zero acting as linear
    foreach (orders[p]) begin
      drain_and_config(orders[p]);
      if (p < 3) begin
        foreach (rows[n]) begin
          r = rows[n];
          send(r.b, (p == 0) ? r.fixed : 1'b0, r.res);
          if ($urandom_range(3) == 0) idle_in($urandom_range(5, 1));
        end
      end
      // Random phase: mostly tracks, loads sprinkled in bursts
      if (p == 3) hold_long = 1'b1;
      for (int n = 0; n < ((p == 1 || p == 4) ? 100 : 210); ) begin
        burst = $urandom_range(12, 1);
        for (int m = 0; m < burst; m++, n++)
          send(($urandom_range(2) == 0) ? rand_load() : rand_track());
        if ($urandom_range(2) != 0) idle_in($urandom_range(40, 1));
      end
    end

    // Drain and let the tail settle
    in_tvalid <= 1'b0;
    while (pending_tracks.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_tracks.size() == 0)
      $display("third_order_transport_map_top_tb OK");
    else
      $display("third_order_transport_map_top_tb NOT OK");
    $finish;
  end

endmodule
